// ===== rtl/ihss_pkg.sv =====
// shared types and constants for the image header size sniffer
`timescale 1ns / 1ps

package ihss_pkg;

   localparam int unsigned POS_WIDTH = 5;
   localparam logic [POS_WIDTH-1:0] POS_MAX = 5'd31;

   localparam int unsigned SIZE_WIDTH = 14;
   localparam logic [31:0] SIZE_LIMIT = 32'd10000;
   // smallest accepted bmp height as a negative 32-bit value
   localparam logic [31:0] BMP_NEG_MIN = 32'd0 - (SIZE_LIMIT - 32'd1);

   localparam int unsigned MIN_LEN = 24;
   localparam int unsigned BMP_MIN_LEN = 26;
   localparam logic [POS_WIDTH-1:0] MIN_LAST_POS = 5'(MIN_LEN - 1);
   localparam logic [POS_WIDTH-1:0] BMP_MIN_LAST_POS = 5'(BMP_MIN_LEN - 1);

   localparam logic [7:0] SIG_PNG0 = 8'h89;
   localparam logic [7:0] SIG_PNG1 = 8'h50;
   localparam logic [7:0] SIG_PNG2 = 8'h4e;
   localparam logic [7:0] SIG_PNG3 = 8'h47;
   localparam logic [7:0] SIG_JPEG0 = 8'hff;
   localparam logic [7:0] SIG_JPEG1 = 8'hd8;
   localparam logic [7:0] SIG_JPEG2 = 8'hff;
   localparam logic [7:0] SIG_GIF0 = 8'h47;
   localparam logic [7:0] SIG_GIF1 = 8'h49;
   localparam logic [7:0] SIG_GIF2 = 8'h46;
   localparam logic [7:0] SIG_BMP0 = 8'h42;
   localparam logic [7:0] SIG_BMP1 = 8'h4d;
   localparam logic [7:0] JPEG_MARK = 8'hff;
   localparam logic [7:0] SOF_FIRST = 8'hc0;
   localparam logic [7:0] SOF_LAST = 8'hc3;

   typedef enum logic [2:0] {
      FMT_NONE = 3'd0,
      FMT_PNG  = 3'd1,
      FMT_JPEG = 3'd2,
      FMT_GIF  = 3'd3,
      FMT_BMP  = 3'd4
   } fmt_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } ihss_byte_type;

   typedef struct packed {
      logic                  found;
      fmt_type               format;
      logic [SIZE_WIDTH-1:0] out_width;
      logic [SIZE_WIDTH-1:0] out_height;
   } ihss_result_type;

endpackage

// ===== rtl/ihss_if.sv =====
// valid/ready channel interfaces for byte words in and size results out
`timescale 1ns / 1ps

interface ihss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihss_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [2:0]                     format;
   logic [ihss_pkg::SIZE_WIDTH-1:0] out_width;
   logic [ihss_pkg::SIZE_WIDTH-1:0] out_height;

   modport source (output valid, output found, output format, output out_width,
                   output out_height, input ready);
   modport sink (input valid, input found, input format, input out_width,
                 input out_height, output ready);
endinterface

// ===== rtl/image_header_size_sniffer_core.sv =====
// top level of the image header size sniffer
`timescale 1ns / 1ps

// Image header size sniffer.
// req_ch carries the bytes of one file buffer, one word per byte, with
// last_byte set on the final byte. rsp_ch returns exactly one word per
// buffer, on the final byte: found, format (png, jpeg, gif, bmp or none)
// and the width and height in pixels, all zero when no size was found.
// A final byte passes the input register and then the result register
// (two register stages, input and result) before its result word is valid.
// Throughput: one byte per cycle unless a final byte waits on a stalled
// result; each byte update is one logic pass, input register to parser state.
// When rsp_ch stalls, the result word holds and bytes of the next buffer
// keep flowing; only a second final byte waits in the input register until
// the pending result is taken.
// Reset (synchronous, active high) clears the channels and parser state;
// the first byte after reset starts a new buffer.

module image_header_size_sniffer_core (
   input logic       clock,
   input logic       reset,
   ihss_req_if.sink   req_ch,
   ihss_rsp_if.source rsp_ch
);

   logic                      in_valid_ff;
   ihss_pkg::ihss_byte_type   in_word_ff;
   logic                      rsp_valid_ff;
   ihss_pkg::ihss_result_type rsp_ff;
   ihss_pkg::ihss_result_type parse_result;

   logic out_free, process, load_result;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign process     = in_valid_ff && (!in_word_ff.last_byte || out_free);
   assign load_result = process && in_word_ff.last_byte;
   assign req_ch.ready = !in_valid_ff || process;

   ihss_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (process),
      .word   (in_word_ff),
      .result (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         if (load_result) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
      if (req_ch.ready) begin
         in_word_ff.data_byte <= req_ch.data_byte;
         in_word_ff.last_byte <= req_ch.last_byte;
      end
      if (load_result) rsp_ff <= parse_result;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_ff.found;
   assign rsp_ch.format     = rsp_ff.format;
   assign rsp_ch.out_width  = rsp_ff.out_width;
   assign rsp_ch.out_height = rsp_ff.out_height;

   // a result word only appears right after a final byte was processed
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_word_ff.last_byte))
      else $error("result word without a final byte");

   // a final byte never overtakes a pending, stalled result
   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_word_ff.last_byte && rsp_valid_ff && !rsp_ch.ready)
      |=> in_valid_ff && in_word_ff.last_byte)
      else $error("final byte consumed while result stalled");

   // not found means every field is zero
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |->
      (rsp_ff.format == ihss_pkg::FMT_NONE && rsp_ff.out_width == 14'd0 &&
       rsp_ff.out_height == 14'd0))
      else $error("fields set on a result with no size");

   // a found size is always in range and has a format
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |->
      (rsp_ff.format != ihss_pkg::FMT_NONE && rsp_ff.out_width != 14'd0 &&
       rsp_ff.out_height != 14'd0 && rsp_ff.out_width < 14'd10000 &&
       rsp_ff.out_height < 14'd10000))
      else $error("found size out of range");

endmodule

// ===== rtl/ihss_parse.sv =====
// header parser: per-word state update and size result for the final word
`timescale 1ns / 1ps

module ihss_parse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  ihss_pkg::ihss_byte_type   word,
   output ihss_pkg::ihss_result_type result
);

   typedef enum logic [3:0] {
      PH_SEARCH = 4'd0,
      PH_MARKER = 4'd1,
      PH_LEN_HI = 4'd2,
      PH_LEN_LO = 4'd3,
      PH_SKIP   = 4'd4,
      PH_FRAME  = 4'd5
   } phase_type;

   typedef enum logic [1:0] {
      DEC_WALK = 2'd0,
      DEC_DONE = 2'd1,
      DEC_FAIL = 2'd2
   } decided_type;

   logic [ihss_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   ihss_pkg::fmt_type              guess_ff, guess_in;
   phase_type                      phase_ff, phase_in;
   logic [15:0]                    skip_ff, skip_in;
   logic [31:0]                    low_ff, low_in;
   logic [31:0]                    high_ff, high_in;
   decided_type                    decided_ff, decided_in;

   logic [7:0]                     b;
   logic [ihss_pkg::POS_WIDTH-1:0] bmp_lo_off, bmp_hi_off;
   logic [15:0]                    seg_len;

   function automatic logic size_ok(input logic [31:0] v);
      size_ok = (v != 32'd0) && (v < ihss_pkg::SIZE_LIMIT);
   endfunction

   always_comb begin
      b          = word.data_byte;
      bmp_lo_off = pos_ff - 5'd18;
      bmp_hi_off = pos_ff - 5'd22;
      seg_len    = skip_ff | {8'd0, b};
      pos_in     = (pos_ff == ihss_pkg::POS_MAX) ? pos_ff : pos_ff + 5'd1;
      guess_in   = guess_ff;
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      decided_in = decided_ff;

      priority if (pos_ff == 5'd0) begin
         priority if (b == ihss_pkg::SIG_PNG0) guess_in = ihss_pkg::FMT_PNG;
         else if (b == ihss_pkg::SIG_JPEG0) guess_in = ihss_pkg::FMT_JPEG;
         else if (b == ihss_pkg::SIG_GIF0) guess_in = ihss_pkg::FMT_GIF;
         else if (b == ihss_pkg::SIG_BMP0) guess_in = ihss_pkg::FMT_BMP;
         else guess_in = ihss_pkg::FMT_NONE;
      end else if (pos_ff == 5'd1) begin
         if (!((guess_ff == ihss_pkg::FMT_PNG && b == ihss_pkg::SIG_PNG1) ||
               (guess_ff == ihss_pkg::FMT_JPEG && b == ihss_pkg::SIG_JPEG1) ||
               (guess_ff == ihss_pkg::FMT_GIF && b == ihss_pkg::SIG_GIF1) ||
               (guess_ff == ihss_pkg::FMT_BMP && b == ihss_pkg::SIG_BMP1)))
            guess_in = ihss_pkg::FMT_NONE;
      end else if (pos_ff == 5'd2) begin
         if (!((guess_ff == ihss_pkg::FMT_PNG && b == ihss_pkg::SIG_PNG2) ||
               (guess_ff == ihss_pkg::FMT_JPEG && b == ihss_pkg::SIG_JPEG2) ||
               (guess_ff == ihss_pkg::FMT_GIF && b == ihss_pkg::SIG_GIF2) ||
               guess_ff == ihss_pkg::FMT_BMP))
            guess_in = ihss_pkg::FMT_NONE;
      end else if (pos_ff == 5'd3 && guess_ff == ihss_pkg::FMT_PNG &&
                   b != ihss_pkg::SIG_PNG3) begin
         guess_in = ihss_pkg::FMT_NONE;
      end else begin
         unique case (guess_ff)
            ihss_pkg::FMT_PNG: begin
               // big endian 32-bit fields
               if (pos_ff >= 5'd16 && pos_ff <= 5'd19) low_in = {low_ff[23:0], b};
               else if (pos_ff >= 5'd20 && pos_ff <= 5'd23) high_in = {high_ff[23:0], b};
            end
            ihss_pkg::FMT_JPEG: begin
               if (decided_ff == DEC_WALK) begin
                  unique case (phase_ff)
                     PH_SEARCH: begin
                        if (b == ihss_pkg::JPEG_MARK) phase_in = PH_MARKER;
                     end
                     PH_MARKER: begin
                        if (b >= ihss_pkg::SOF_FIRST && b <= ihss_pkg::SOF_LAST) begin
                           phase_in = PH_FRAME;
                           skip_in  = 16'd0;
                           low_in   = 32'd0;
                           high_in  = 32'd0;
                        end else begin
                           phase_in = PH_LEN_HI;
                        end
                     end
                     PH_LEN_HI: begin
                        skip_in  = {b, 8'd0};
                        phase_in = PH_LEN_LO;
                     end
                     PH_LEN_LO: begin
                        if (seg_len < 16'd2) begin
                           skip_in    = seg_len;
                           decided_in = DEC_FAIL;
                        end else begin
                           skip_in  = seg_len - 16'd2;
                           phase_in = (seg_len != 16'd2) ? PH_SKIP : PH_SEARCH;
                        end
                     end
                     PH_SKIP: begin
                        skip_in = skip_ff - 16'd1;
                        if (skip_ff == 16'd1) phase_in = PH_SEARCH;
                     end
                     default: begin
                        // frame header: precision, height, width
                        if (skip_ff == 16'd3) high_in = {16'd0, b, 8'd0};
                        else if (skip_ff == 16'd4) high_in = high_ff | {24'd0, b};
                        else if (skip_ff == 16'd5) low_in = {16'd0, b, 8'd0};
                        else if (skip_ff == 16'd6) begin
                           low_in     = low_ff | {24'd0, b};
                           decided_in = DEC_DONE;
                        end
                        skip_in = skip_ff + 16'd1;
                     end
                  endcase
               end
            end
            ihss_pkg::FMT_GIF: begin
               if (pos_ff == 5'd6) low_in = low_ff | {24'd0, b};
               else if (pos_ff == 5'd7) low_in = low_ff | {16'd0, b, 8'd0};
               else if (pos_ff == 5'd8) high_in = high_ff | {24'd0, b};
               else if (pos_ff == 5'd9) high_in = high_ff | {16'd0, b, 8'd0};
            end
            ihss_pkg::FMT_BMP: begin
               if (pos_ff >= 5'd18 && pos_ff <= 5'd21)
                  low_in = low_ff | ({24'd0, b} << {bmp_lo_off[1:0], 3'b000});
               else if (pos_ff >= 5'd22 && pos_ff <= 5'd25)
                  high_in = high_ff | ({24'd0, b} << {bmp_hi_off[1:0], 3'b000});
            end
            default: ;
         endcase
      end
   end

   logic                            len_ok, kind_ok, h_ok, ok;
   logic [ihss_pkg::SIZE_WIDTH-1:0] h_abs;

   always_comb begin
      len_ok = pos_ff >= ihss_pkg::MIN_LAST_POS;
      h_abs  = high_in[31] ? 14'(~high_in[13:0] + 14'd1) : high_in[13:0];
      kind_ok = 1'b0;
      h_ok    = size_ok(high_in);
      unique case (guess_in)
         ihss_pkg::FMT_PNG,
         ihss_pkg::FMT_GIF:  kind_ok = 1'b1;
         ihss_pkg::FMT_JPEG: kind_ok = (decided_in == DEC_DONE);
         ihss_pkg::FMT_BMP: begin
            kind_ok = pos_ff >= ihss_pkg::BMP_MIN_LAST_POS;
            // negative heights count by magnitude
            h_ok    = size_ok(high_in) ||
                      (high_in[31] && high_in >= ihss_pkg::BMP_NEG_MIN);
         end
         default: kind_ok = 1'b0;
      endcase
      ok = len_ok && kind_ok && size_ok(low_in) && h_ok;

      result.found      = ok;
      result.format     = ok ? guess_in : ihss_pkg::FMT_NONE;
      result.out_width  = ok ? low_in[13:0] : 14'd0;
      result.out_height = ok ? h_abs : 14'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && word.last_byte)) begin
         pos_ff     <= '0;
         guess_ff   <= ihss_pkg::FMT_NONE;
         phase_ff   <= PH_SEARCH;
         skip_ff    <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         decided_ff <= DEC_WALK;
      end else if (step) begin
         pos_ff     <= pos_in;
         guess_ff   <= guess_in;
         phase_ff   <= phase_in;
         skip_ff    <= skip_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         decided_ff <= decided_in;
      end
   end

endmodule
